[src/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg - palette memory writer shared definitions
// Sizes, codes, state type, control structs and the color conversion.
// ----------------------------------------------------------------------------
package cpr_pkg;

    // palette geometry
    localparam int NUM_PALETTES       = 8;
    localparam int COLORS_PER_PALETTE = 4;
    localparam int ENTRIES            = NUM_PALETTES * COLORS_PER_PALETTE;
    localparam int SLOT_W             = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // index register fields (fixed by the register layout)
    localparam int PAL_W = 3;
    localparam int COL_W = 2;

    // config port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_PIXEL_FORMAT = 1'b0;

    // reset contents of the two memories
    localparam logic [15:0] BG_RESET_WORD  = 16'h7FFF;
    localparam logic [15:0] OBJ_RESET_WORD = 16'h0000;

    // index register bits
    localparam int IDX_AUTO_INC_BIT = 7;

    typedef enum logic {
        CMD_INDEX = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        FMT_RGB565 = 2'd0,
        FMT_BGR565 = 2'd1,
        FMT_RGB555 = 2'd2,
        FMT_BGR555 = 2'd3
    } pixel_fmt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_OLD,
        S_WRITE,
        S_READ_NOW,
        S_LOAD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic rd;
        logic wr;
        logic load;
    } cpr_cmd_t;

    // status seen by the controller
    typedef struct packed {
        logic in_valid;
        logic in_is_data;
        logic out_free;
    } cpr_sts_t;

    // palette number of an index
    function automatic logic [PAL_W-1:0] pal_of(input logic [7:0] idx);
        pal_of = idx[5:3];
    endfunction

    // color number of an index
    function automatic logic [COL_W-1:0] col_of(input logic [7:0] idx);
        col_of = idx[2:1];
    endfunction

    // palette exists in this build
    function automatic logic pal_present(input logic [7:0] idx);
        pal_present = (int'(pal_of(idx)) < NUM_PALETTES);
    endfunction

    // memory slot addressed by an index
    function automatic logic [SLOT_W-1:0] slot_of(input logic [7:0] idx);
        slot_of = SLOT_W'(int'(pal_of(idx)) * COLORS_PER_PALETTE + int'(col_of(idx)));
    endfunction

    // native word to output pixel format
    function automatic logic [15:0] to_render(input logic [15:0] w, input pixel_fmt_t fmt);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        logic [5:0] g6;
        r  = w[4:0];
        g  = w[9:5];
        b  = w[14:10];
        g6 = {g, g[4]};
        unique case (fmt)
            FMT_RGB565: to_render = {r, g6, b};
            FMT_BGR565: to_render = {b, g6, r};
            FMT_RGB555: to_render = {1'b1, r, g, b};
            FMT_BGR555: to_render = {1'b1, b, g, r};
            default:    to_render = {r, g6, b};
        endcase
    endfunction

endpackage

[src/cpr_ifs.sv]
// ----------------------------------------------------------------------------
// cpr_ifs - request and result channels
// Valid/ready channels carrying palette requests and their results.
// ----------------------------------------------------------------------------
interface cpr_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       is_background;
    logic [7:0] value;

    modport source (output valid, output cmd, output is_background, output value,
                    input ready);
    modport sink   (input valid, input cmd, input is_background, input value,
                    output ready);
endinterface

interface cpr_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index_value;
    logic [7:0]  readback_byte;
    logic [2:0]  entry_palette;
    logic [1:0]  entry_color;
    logic [15:0] entry_native;
    logic [15:0] entry_render;

    modport source (output valid, output index_value, output readback_byte,
                    output entry_palette, output entry_color, output entry_native,
                    output entry_render, input ready);
    modport sink   (input valid, input index_value, input readback_byte,
                    input entry_palette, input entry_color, input entry_native,
                    input entry_render, output ready);
endinterface

[src/cpr_ram.sv]
// ----------------------------------------------------------------------------
// cpr_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl - request sequencer
// Steps each request through read, write, read-back and result load.
// ----------------------------------------------------------------------------
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cpr_sts_t sts,
    output logic     in_ready,
    output cpr_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.capture = 1'b1;
                    // index writes need no old word
                    state_next  = sts.in_is_data ? S_READ_OLD : S_WRITE;
                end
            end
            S_READ_OLD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr     = 1'b1;
                state_next = S_READ_NOW;
            end
            S_READ_NOW:
            begin
                cmd.rd     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/cpr_dpath.sv]
// ----------------------------------------------------------------------------
// cpr_dpath - palette memory datapath
// Index registers, both palette RAMs with valid bits, byte merge and
// the output register.
// ----------------------------------------------------------------------------
module cpr_dpath
    import cpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cpr_cmd_t    cmd,
    input  logic        in_cmd,
    input  logic        in_is_background,
    input  logic [7:0]  in_value,
    input  pixel_fmt_t  fmt,
    output logic        out_free,
    cpr_rsp_if.source   result
);

    // captured request
    logic        cmd_reg;
    logic        bg_reg;
    logic [7:0]  value_reg;

    logic [7:0]  bg_index_reg;
    logic [7:0]  obj_index_reg;
    logic [7:0]  bg_index_next;
    logic [7:0]  obj_index_next;

    logic [ENTRIES-1:0] bg_valid_reg;
    logic [ENTRIES-1:0] obj_valid_reg;

    logic        rd_valid_reg;
    logic        rd_present_reg;
    logic [7:0]  entry_idx_reg;
    logic [15:0] word_reg;

    logic        out_valid_reg;
    logic [7:0]  out_index_reg;
    logic [7:0]  out_byte_reg;
    logic [2:0]  out_pal_reg;
    logic [1:0]  out_col_reg;
    logic [15:0] out_native_reg;
    logic [15:0] out_render_reg;

    logic [7:0]        cur_index;
    logic [SLOT_W-1:0] cur_slot;
    logic              cur_present;
    logic [15:0]       bg_rdata;
    logic [15:0]       obj_rdata;
    logic [15:0]       rd_word;
    logic [15:0]       merged;
    logic [7:0]        inc_index;
    logic [7:0]        new_index;
    logic              is_data;
    logic              mem_we;
    logic [15:0]       now_word;
    logic [15:0]       native_sel;

    assign is_data     = (cmd_reg == CMD_DATA);
    assign cur_index   = bg_reg ? bg_index_reg : obj_index_reg;
    assign cur_slot    = slot_of(cur_index);
    assign cur_present = pal_present(cur_index);

    // word read: absent palette reads zero, unwritten entry its reset value
    always_comb
    begin
        if (!rd_present_reg)
        begin
            rd_word = '0;
        end
        else if (!rd_valid_reg)
        begin
            rd_word = bg_reg ? BG_RESET_WORD : OBJ_RESET_WORD;
        end
        else
        begin
            rd_word = bg_reg ? bg_rdata : obj_rdata;
        end
    end

    // byte merge at the current index
    assign merged = cur_index[0] ? {value_reg, rd_word[7:0]} : {rd_word[15:8], value_reg};

    // auto-increment: 6-bit wrap, bit 6 cleared, bit 7 kept
    assign inc_index = {cur_index[IDX_AUTO_INC_BIT], 1'b0, 6'(cur_index[5:0] + 6'd1)};

    always_comb
    begin
        if (!is_data)
        begin
            new_index = value_reg;
        end
        else if (cur_index[IDX_AUTO_INC_BIT])
        begin
            new_index = inc_index;
        end
        else
        begin
            new_index = cur_index;
        end
    end

    assign mem_we = cmd.wr && is_data && cur_present;

    // palette memories
    cpr_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_bg_ram (
        .clk   (clk),
        .we    (mem_we && bg_reg),
        .waddr (cur_slot),
        .wdata (merged),
        .re    (cmd.rd && bg_reg),
        .raddr (cur_slot),
        .rdata (bg_rdata)
    );

    cpr_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_obj_ram (
        .clk   (clk),
        .we    (mem_we && !bg_reg),
        .waddr (cur_slot),
        .wdata (merged),
        .re    (cmd.rd && !bg_reg),
        .raddr (cur_slot),
        .rdata (obj_rdata)
    );

    // request capture, per-read and per-write side info
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= in_cmd;
            bg_reg    <= in_is_background;
            value_reg <= in_value;
        end
        if (cmd.rd)
        begin
            rd_valid_reg   <= bg_reg ? bg_valid_reg[cur_slot] : obj_valid_reg[cur_slot];
            rd_present_reg <= cur_present;
        end
        if (cmd.wr)
        begin
            entry_idx_reg <= is_data ? cur_index : value_reg;
            word_reg      <= cur_present ? merged : 16'h0000;
        end
    end

    // index register updates
    always_comb
    begin
        bg_index_next  = bg_index_reg;
        obj_index_next = obj_index_reg;
        if (cmd.wr)
        begin
            if (bg_reg)
            begin
                bg_index_next = new_index;
            end
            else
            begin
                obj_index_next = new_index;
            end
        end
    end

    // index registers and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_index_reg  <= '0;
            obj_index_reg <= '0;
            bg_valid_reg  <= '0;
            obj_valid_reg <= '0;
        end
        else
        begin
            bg_index_reg  <= bg_index_next;
            obj_index_reg <= obj_index_next;
            if (mem_we && bg_reg)
            begin
                bg_valid_reg[cur_slot] <= 1'b1;
            end
            if (mem_we && !bg_reg)
            begin
                obj_valid_reg[cur_slot] <= 1'b1;
            end
        end
    end

    // result assembly
    assign now_word   = rd_word;
    assign native_sel = is_data ? word_reg : now_word;
    assign out_free   = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_index_reg  <= cur_index;
            out_byte_reg   <= cur_index[0] ? now_word[15:8] : now_word[7:0];
            out_pal_reg    <= pal_of(entry_idx_reg);
            out_col_reg    <= col_of(entry_idx_reg);
            out_native_reg <= native_sel;
            out_render_reg <= to_render(native_sel, fmt);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.index_value   = out_index_reg;
    assign result.readback_byte = out_byte_reg;
    assign result.entry_palette = out_pal_reg;
    assign result.entry_color   = out_col_reg;
    assign result.entry_native  = out_native_reg;
    assign result.entry_render  = out_render_reg;

endmodule

[src/color_palette_ram_writer_core.sv]
// ----------------------------------------------------------------------------
// color_palette_ram_writer_core - palette memory writer top level
// Background and sprite palette RAMs with auto-incrementing index
// registers, reporting each written entry in the configured pixel format.
// ----------------------------------------------------------------------------
// Usage:
//   req  - valid/ready request channel: cmd (0 index write, 1 data byte),
//          is_background, value.
//   rsp  - valid/ready result channel, one result per request.
//   APB  - register 0 (byte address 0) holds pixel_format; write it only
//          while no request is in flight. pready is tied high.
// Sequence:
//   An index request passes through write, read-back and result load; a data
//   request through old word read, merge and write, read-back and result load.
//   A new request is accepted the cycle after a result is loaded, so a request
//   is not taken until the one before it has been loaded as a result.
// Stall: a waiting result sits in the output register while the next request
//   is accepted and processed; that request holds in its load step until the
//   output register frees up.
// Reset: index registers and pixel_format clear; per-entry valid bits make
//   background entries read 0x7FFF and sprite entries read zero until written.
// ----------------------------------------------------------------------------
module color_palette_ram_writer_core
    import cpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    cpr_req_if.sink               req,
    cpr_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    pixel_fmt_t fmt_reg;
    cpr_cmd_t   cmd;
    cpr_sts_t   sts;
    logic       in_ready;
    logic       out_free;
    logic       reg_sel;

    // config register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_PIXEL_FORMAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RGB565;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            fmt_reg <= pixel_fmt_t'(pwdata[1:0]);
        end
    end

    assign prdata = reg_sel ? {{(CFG_DATA_W-2){1'b0}}, fmt_reg} : '0;

    // status to the sequencer
    assign sts.in_valid   = req.valid;
    assign sts.in_is_data = (req.cmd == CMD_DATA);
    assign sts.out_free   = out_free;
    assign req.ready      = in_ready;

    cpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    cpr_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .in_cmd           (req.cmd),
        .in_is_background (req.is_background),
        .in_value         (req.value),
        .fmt              (fmt_reg),
        .out_free         (out_free),
        .result           (rsp)
    );

endmodule
